// ===== design/spq_pkg.sv =====
// Shared types, constants and helpers for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic signed [15:0] PRIO_MIN_RST = 16'sd0;
  localparam logic signed [15:0] PRIO_MAX_RST = 16'sd100;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_PRIO_MIN = 1'b0,
    CFG_PRIO_MAX = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_ctl_t;

  // count or position squeezed into the 5-bit result fields
  function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_CNT_W-1:0] t;
    t = {{OUT_CNT_W{1'b0}}, v};
    return t[OUT_CNT_W-1:0];
  endfunction

endpackage

// ===== design/spq_cell.sv =====
// One storage cell: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic signed [31:0] new_value_i,
  input  logic signed [15:0] new_prio_i,
  input  logic               left_gt_i,
  input  logic signed [31:0] left_value_i,
  input  logic signed [15:0] left_prio_i,
  input  logic signed [31:0] right_value_i,
  input  logic signed [15:0] right_prio_i,
  output logic signed [31:0] value_o,
  output logic signed [15:0] prio_o,
  output logic               gt_o,
  output logic               hit_o
);
  import spq_pkg::*;

  logic signed [31:0] value_q, value_d;
  logic signed [15:0] prio_q, prio_d;

  // stored entry outranks the incoming one: it stays put
  assign gt_o  = occ_i && (prio_q > new_prio_i);
  assign hit_o = occ_i && (value_q == new_value_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctl_i.ins_en && !gt_o) begin
      if (left_gt_i) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end else begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end
    end else if (ctl_i.pop_en) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ===== design/spq_chain.sv =====
// Row of storage cells wired head to tail.
module spq_chain (
  input  logic                      clk_i,
  input  spq_pkg::cell_ctl_t        ctl_i,
  input  logic [spq_pkg::CNT_W-1:0] count_i,
  input  logic signed [31:0]        new_value_i,
  input  logic signed [15:0]        new_prio_i,
  output logic signed [31:0]        head_value_o,
  output logic signed [15:0]        head_prio_o,
  output logic [spq_pkg::DEPTH-1:0] hit_o
);
  import spq_pkg::*;

  logic signed [31:0] value [DEPTH];
  logic signed [15:0] prio  [DEPTH];
  logic [DEPTH-1:0]   gt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               occ;
    logic               left_gt;
    logic signed [31:0] left_value, right_value;
    logic signed [15:0] left_prio, right_prio;

    assign occ = CNT_W'(i) < count_i;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b1;
      assign left_value = new_value_i;
      assign left_prio  = new_prio_i;
    end else begin : g_body
      assign left_gt    = gt[i-1];
      assign left_value = value[i-1];
      assign left_prio  = prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = value[i];
      assign right_prio  = prio[i];
    end else begin : g_mid
      assign right_value = value[i+1];
      assign right_prio  = prio[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl_i),
      .occ_i         (occ),
      .new_value_i   (new_value_i),
      .new_prio_i    (new_prio_i),
      .left_gt_i     (left_gt),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .value_o       (value[i]),
      .prio_o        (prio[i]),
      .gt_o          (gt[i]),
      .hit_o         (hit_o[i])
    );
  end

  assign head_value_o = value[0];
  assign head_prio_o  = prio[0];

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// Sorted priority queue: sequencer, config registers and cell chain.
// Flow: an accepted item passes the execute step in the cell chain, then the respond
//   step, which resolves the response and registers the result.
// The sequencer takes a new item only in idle, after the last result is registered;
//   a result not yet taken holds the respond step.
// Reset: count, sequencer and output valid clear; priority_min = 0 and
//   priority_max = 100; stored entries are not cleared (never read when empty).
module sorted_priority_queue_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic signed [31:0]  value_i,
  input  logic signed [15:0]  priority_req_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic signed [31:0]  out_value_o,
  output logic signed [15:0]  out_priority_o,
  output logic [4:0]          position_o,
  output logic [4:0]          count_o,
  // config writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic signed [15:0]  cfg_data_i
);
  import spq_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [15:0] pmin_q, pmax_q;

  // latched command
  op_e                op_q;
  logic signed [31:0] val_q;
  logic signed [15:0] pri_q;

  // execute-cycle results
  status_e            st_q;
  logic signed [31:0] res_val_q;
  logic signed [15:0] res_pri_q;
  logic [DEPTH-1:0]   hit_q;

  // output register
  logic               out_valid_q;
  status_e            out_st_q;
  logic signed [31:0] out_val_q;
  logic signed [15:0] out_pri_q;
  logic [4:0]         out_pos_q, out_cnt_q;

  cell_ctl_t          ctl;
  logic signed [31:0] head_value;
  logic signed [15:0] head_prio;
  logic [DEPTH-1:0]   hit;
  logic               in_fire, out_free, in_range, full, empty;
  status_e            st_exec, st_resp;
  logic [CNT_W-1:0]   pos;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign in_range = (pri_q >= pmin_q) && (pri_q <= pmax_q);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);

  // Execute step: decide status and drive the cells.
  always_comb begin
    ctl     = '0;
    st_exec = ST_OK;
    count_d = count_q;
    if (state_q == S_EXEC) begin
      case (op_q)
        OP_INSERT: begin
          // range check wins over the full check
          if (!in_range) begin
            st_exec = ST_RANGE;
          end else if (full) begin
            st_exec = ST_FULL;
          end else begin
            ctl.ins_en = 1'b1;
            count_d    = count_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            st_exec = ST_EMPTY;
          end else begin
            ctl.pop_en = 1'b1;
            count_d    = count_q - 1'b1;
          end
        end
        OP_PEEK: begin
          if (empty) st_exec = ST_EMPTY;
        end
        OP_SEARCH: begin
          st_exec = empty ? ST_EMPTY : ST_NOTFOUND;
        end
        default: st_exec = ST_OK;
      endcase
    end
  end

  // first hit from the head
  always_comb begin
    pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_q[i]) pos = CNT_W'(i + 1);
    end
  end

  assign st_resp = (st_q == ST_NOTFOUND && |hit_q) ? ST_OK : st_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pmin_q      <= PRIO_MIN_RST;
      pmax_q      <= PRIO_MAX_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PRIO_MIN: pmin_q <= cfg_data_i;
          CFG_PRIO_MAX: pmax_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(operation_i);
      val_q <= value_i;
      pri_q <= priority_req_i;
    end
    if (state_q == S_EXEC) begin
      st_q  <= st_exec;
      hit_q <= (op_q == OP_SEARCH) ? hit : '0;
      if ((op_q == OP_REMOVE || op_q == OP_PEEK) && !empty) begin
        res_val_q <= head_value;
        res_pri_q <= head_prio;
      end else begin
        res_val_q <= '0;
        res_pri_q <= '0;
      end
    end
    if (state_q == S_RESP && out_free) begin
      out_st_q  <= st_resp;
      out_val_q <= res_val_q;
      out_pri_q <= res_pri_q;
      out_pos_q <= to_out_cnt(pos);
      out_cnt_q <= to_out_cnt(count_q);
    end
  end

  spq_chain u_chain (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .count_i      (count_q),
    .new_value_i  (val_q),
    .new_prio_i   (pri_q),
    .head_value_o (head_value),
    .head_prio_o  (head_prio),
    .hit_o        (hit)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_value_o    = out_val_q;
  assign out_priority_o = out_pri_q;
  assign position_o     = out_pos_q;
  assign count_o        = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");
  a_no_ins_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins_en |-> !full && !ctl.pop_en)
    else $error("insert into full store or with pop");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pop_en |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not decrement count");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !out_free) |=> state_q == S_RESP && $stable(out_st_q))
    else $error("response lost while output busy");
`endif

endmodule

// ===== tb/spq_order_checker.sv =====
// Scoreboard for the sorted priority queue: shadow store, replies due, field compare.
`timescale 1ns / 1ps
module spq_order_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic signed [15:0] priority_req_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] out_value_i,
  input  logic signed [15:0] out_priority_i,
  input  logic [4:0]         position_i,
  input  logic [4:0]         count_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [0:0]         cfg_index_i,
  input  logic signed [15:0] cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o,
  output logic [4:0]         status_seen_o
);
  import spq_pkg::*;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] value;
    logic signed [15:0] prio;
    logic [4:0]         position;
    logic [4:0]         count;
  } reply_t;

  localparam int unsigned MAX_REPORTS = 10;

  logic signed [31:0] shadow_value [DEPTH];
  logic signed [15:0] shadow_prio  [DEPTH];
  int unsigned        shadow_count = 0;
  logic signed [15:0] lo_prio      = PRIO_MIN_RST;
  logic signed [15:0] hi_prio      = PRIO_MAX_RST;

  reply_t      replies_due [$];
  int unsigned fails    = 0;
  int unsigned reported = 0;
  int unsigned checked  = 0;
  logic [4:0]  seen     = '0;

  // Applies one operation to the shadow store and returns the reply it must give.
  function automatic reply_t apply_queue_op(input op_e op, input logic signed [31:0] val,
                                            input logic signed [15:0] pri);
    reply_t      r;
    int unsigned at;
    int unsigned k;
    logic        hit;
    r        = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      // range check wins over the full check
      if (pri < lo_prio || pri > hi_prio) begin
        r.status = ST_RANGE;
      end else if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes ahead of the first one not strictly higher
        at = 0;
        while (at < shadow_count && shadow_prio[at] > pri) at++;
        for (k = shadow_count; k > at; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[at] = val;
        shadow_prio[at]  = pri;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_SEARCH) begin
      hit      = 1'b0;
      r.status = ST_NOTFOUND;
      for (k = 0; k < shadow_count; k++) begin
        if (!hit && shadow_value[k] == val) begin
          hit        = 1'b1;
          r.status   = ST_OK;
          r.position = 5'(k + 1);
        end
      end
    end else begin
      r.value = shadow_value[0];
      r.prio  = shadow_prio[0];
      if (op == OP_REMOVE) begin
        for (k = 1; k < shadow_count; k++) begin
          shadow_value[k-1] = shadow_value[k];
          shadow_prio[k-1]  = shadow_prio[k];
        end
        shadow_count--;
      end
    end
    r.count = 5'(shadow_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      shadow_count = 0;
      lo_prio      = PRIO_MIN_RST;
      hi_prio      = PRIO_MAX_RST;
      replies_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_PRIO_MIN) lo_prio = cfg_data_i;
        else hi_prio = cfg_data_i;
      end

      // compare before predicting: an item taken this edge answers later
      if (out_valid_i && out_ready_i) begin
        got.status   = status_e'(status_i);
        got.value    = out_value_i;
        got.prio     = out_priority_i;
        got.position = position_i;
        got.count    = count_i;
        checked++;
        if (status_i < 3'd5) seen[status_i] = 1'b1;
        if (replies_due.size() == 0) begin
          fails++;
          if (reported < MAX_REPORTS)
            $display("[%0t] result with nothing outstanding: st=%0d val=%h pri=%0d",
                     $time, status_i, out_value_i, out_priority_i);
          reported++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            fails++;
            if (reported < MAX_REPORTS)
              $display({"[%0t] result %0d mismatch: want st=%0d val=%h pri=%0d pos=%0d ",
                        "cnt=%0d, got st=%0d val=%h pri=%0d pos=%0d cnt=%0d"},
                       $time, checked, want.status, want.value, want.prio,
                       want.position, want.count, status_i, out_value_i,
                       out_priority_i, position_i, count_i);
            reported++;
          end
        end
      end

      if (in_valid_i && in_ready_i)
        replies_due.push_back(apply_queue_op(op_e'(operation_i), value_i, priority_req_i));
    end
    fail_count_o  <= fails;
    pending_o     <= replies_due.size();
    checked_o     <= checked;
    status_seen_o <= seen;
  end

endmodule

// ===== tb/tb_sorted_priority_queue_top.sv =====
// Testbench top for the sorted priority queue: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  // The slowest legal item is a source gap, its trip through the block and a result stall;
  // ~1620 items plus one long stall and drains stays far below this.
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned STALL_CYCLES    = 200;

  // idle styles, drawn per item on either side
  localparam int GAP_NONE = 0;  // back-to-back
  localparam int GAP_ANY  = 1;  // random gap every item
  localparam int GAP_SOME = 2;  // mostly none, now and then a random gap

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [1:0]         item_op    = OP_INSERT;
  logic signed [31:0] item_value = '0;
  logic signed [15:0] item_prio  = '0;
  logic               reply_valid;
  logic               reply_ready = 1'b0;
  logic [2:0]         reply_status;
  logic signed [31:0] reply_value;
  logic signed [15:0] reply_prio;
  logic [4:0]         reply_position;
  logic [4:0]         reply_count;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [0:0]         cfg_index  = CFG_PRIO_MIN;
  logic signed [15:0] cfg_data   = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  logic [4:0]  status_seen;

  int          src_gap_style = GAP_SOME;
  int          snk_gap_style = GAP_SOME;
  bit          stall_request = 1'b0;  // set by stimulus
  bit          stall_done    = 1'b0;  // set by the result side once the hold-off is over
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_priority_queue_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (item_valid),
    .in_ready_o     (item_ready),
    .operation_i    (item_op),
    .value_i        (item_value),
    .priority_req_i (item_prio),
    .out_valid_o    (reply_valid),
    .out_ready_i    (reply_ready),
    .status_o       (reply_status),
    .out_value_o    (reply_value),
    .out_priority_o (reply_prio),
    .position_o     (reply_position),
    .count_o        (reply_count),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  spq_order_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (item_valid),
    .in_ready_i     (item_ready),
    .operation_i    (item_op),
    .value_i        (item_value),
    .priority_req_i (item_prio),
    .out_valid_i    (reply_valid),
    .out_ready_i    (reply_ready),
    .status_i       (reply_status),
    .out_value_i    (reply_value),
    .out_priority_i (reply_prio),
    .position_i     (reply_position),
    .count_i        (reply_count),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .status_seen_o  (status_seen)
  );

  function automatic int unsigned draw_gap(input int style);
    int unsigned gap;
    gap = 0;
    if (style == GAP_ANY) gap = $urandom_range(0, 15);
    else if (style == GAP_SOME && $urandom_range(0, 3) == 0) gap = $urandom_range(0, 15);
    return gap;
  endfunction

  // Small values dominate so that searches hit and duplicates occur;
  // full-width randoms and the corner words toggle every bit.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = 32'($urandom_range(0, 7));
      2:    v = 32'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = -32'sd1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly inside [lo, hi]; the bounds, just outside them, and anything at all.
  function automatic logic signed [15:0] pick_prio(input int lo, input int hi);
    logic signed [15:0] p;
    case ($urandom_range(0, 9))
      0: p = 16'($urandom());
      1: p = 16'(lo - 1);
      2: p = 16'(hi + 1);
      3: p = 16'(lo);
      4: p = 16'(hi);
      default: begin
        if (lo > hi) p = 16'($urandom());
        else p = 16'(lo + int'($urandom_range(0, hi - lo)));
      end
    endcase
    return p;
  endfunction

  function automatic op_e pick_op(input int insert_pct);
    int unsigned r;
    op_e         op;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      op = OP_INSERT;
    end else begin
      case ($urandom_range(0, 4))
        0, 1:    op = OP_REMOVE;
        2:       op = OP_PEEK;
        default: op = OP_SEARCH;
      endcase
    end
    return op;
  endfunction

  // Offer one item and hold it until taken. Valid is only dropped when a gap
  // follows, so a back-to-back item never sees valid fall and rise in one step.
  task automatic send_item(input op_e op, input logic signed [31:0] val,
                           input logic signed [15:0] pri);
    int unsigned gap;
    gap = draw_gap(src_gap_style);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_op    <= op;
    item_value <= val;
    item_prio  <= pri;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result. The checker's count
  // is registered, so it is only trusted once it has been updated.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Both range registers, back to back, while the block is idle.
  task automatic program_range(input int lo, input int hi);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PRIO_MIN;
    cfg_data  <= 16'(lo);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PRIO_MAX;
    cfg_data  <= 16'(hi);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Result side: own gap per item, plus one long hold-off on request while
  // the sender keeps pushing, so the block backs up and drops in_ready.
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      if (stall_request && !stall_done) begin
        reply_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end
      gap = draw_gap(snk_gap_style);
      if (gap != 0) begin
        reply_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      reply_ready <= 1'b1;
      do @(posedge clk); while (!reply_valid);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles, %0d results outstanding",
             cycle_count, pending);
    $display("sorted_priority_queue_top regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    int          lo;
    int          hi;
    int          ins_pct;
    int unsigned p;
    int unsigned n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset range [0, 100].
    // Empty store: every non-insert reports empty.
    send_item(OP_REMOVE, 32'sd0, 16'sd0);
    send_item(OP_PEEK,   32'sd0, 16'sd0);
    send_item(OP_SEARCH, 32'sd0, 16'sd0);
    // Range bounds accepted, both extremes of the value field.
    send_item(OP_INSERT, 32'sh7fff_ffff, 16'sd100);
    send_item(OP_INSERT, 32'sh8000_0000, 16'sd0);
    // Just outside the range, and the priority field extremes.
    send_item(OP_INSERT, 32'sd5,  -16'sd1);
    send_item(OP_INSERT, 32'sd6,  16'sd101);
    send_item(OP_INSERT, -32'sd1, 16'sh8000);
    send_item(OP_INSERT, 32'sd9,  16'sh7fff);
    // Equal priorities: the later insert must land ahead of the earlier one.
    send_item(OP_INSERT, 32'sd11, 16'sd50);
    send_item(OP_INSERT, 32'sd12, 16'sd50);
    // Search hits in the middle and at the tail, then a miss.
    send_item(OP_SEARCH, 32'sd12, 16'sd0);
    send_item(OP_SEARCH, 32'sd11, 16'sd0);
    send_item(OP_SEARCH, 32'sh8000_0000, 16'sd0);
    send_item(OP_SEARCH, 32'sd77, 16'sd0);
    send_item(OP_PEEK,   32'sd0,  16'sd0);
    // Drain to empty and once more past it.
    repeat (4) send_item(OP_REMOVE, 32'sd0, 16'sd0);
    send_item(OP_REMOVE, 32'sd0, 16'sd0);
    send_item(OP_SEARCH, 32'sd12, 16'sd0);
    wait_drained();

    // Random phases, each under its own range setting and idle styles.
    // The store carries over, so entries outside a new range stay put.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin  // full span, insert-heavy: reaches the full store
          lo = -32768; hi = 32767; ins_pct = 70;
          src_gap_style = GAP_ANY;  snk_gap_style = GAP_ANY;
        end
        1: begin  // narrow band, many ties; sender flat out for the hold-off
          lo = -5; hi = 5; ins_pct = 60;
          src_gap_style = GAP_NONE; snk_gap_style = GAP_SOME;
        end
        2: begin  // inverted range: every insert rejected, store drains
          lo = 100; hi = -100; ins_pct = 50;
          src_gap_style = GAP_SOME; snk_gap_style = GAP_NONE;
        end
        3: begin  // single accepted priority
          lo = 7; hi = 7; ins_pct = 60;
          src_gap_style = GAP_ANY;  snk_gap_style = GAP_ANY;
        end
        4: begin  // top of the priority field only
          lo = 32767; hi = 32767; ins_pct = 55;
          src_gap_style = GAP_NONE; snk_gap_style = GAP_NONE;
        end
        5: begin  // bottom of the priority field only
          lo = -32768; hi = -32768; ins_pct = 45;
          src_gap_style = GAP_SOME; snk_gap_style = GAP_ANY;
        end
        6: begin  // random ordered pair
          lo = int'($urandom_range(0, 65535)) - 32768;
          hi = int'($urandom_range(0, 65535)) - 32768;
          if (lo > hi) begin
            n  = lo;
            lo = hi;
            hi = n;
          end
          ins_pct = 65;
          src_gap_style = GAP_ANY;  snk_gap_style = GAP_SOME;
        end
        default: begin  // back to reset values, removal-heavy
          lo = 0; hi = 100; ins_pct = 30;
          src_gap_style = GAP_ANY;  snk_gap_style = GAP_ANY;
        end
      endcase
      program_range(lo, hi);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 40) stall_request = 1'b1;
        send_item(pick_op(ins_pct), pick_value(), pick_prio(lo, hi));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);

    $display("Covered %0d items over %0d range settings incl. inverted and extreme bounds;",
             items_sent, NUM_PHASES + 1);
    $display("%0d results compared, %0d failures, status codes seen (bit per code) %b",
             checked, fail_count, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_priority_queue_top regression: pass");
    end else begin
      $display("sorted_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule
